// ===== rtl/core/epbf_pkg.sv =====
package epbf_pkg;

    localparam int OUT_W      = 16;
    localparam int WT_W       = 17;
    localparam int THR_W      = 16;
    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int KIND_W     = 2;
    localparam int MUL_STEPS  = 17;
    localparam int DIV_STEPS  = 16;
    localparam int CNT_W      = 5;
    localparam int WT_FRAC    = 16;
    localparam int OUT_MAX    = 32767;
    localparam int OUT_MIN    = -32768;

    localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESH = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_MUL,
        ST_UPD,
        ST_RCHK,
        ST_DIV,
        ST_RDIFF,
        ST_RSUM,
        ST_ROUT
    } state_t;

    typedef struct packed {
        state_t st;
        logic   in_ready;
    } ctrl_t;

    typedef struct packed {
        logic              in_fire;
        logic [KIND_W-1:0] in_kind;
        logic [KIND_W-1:0] kind;
        logic              go_blend;
        logic              full_wt;
        logic              out_free;
    } sts_t;

endpackage

// ===== rtl/core/epbf_in_if.sv =====
interface epbf_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [epbf_pkg::KIND_W-1:0]  kind;
    logic [SAMPLE_WIDTH-1:0]      sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink (input valid, input kind, input sample, output ready);
endinterface

// ===== rtl/core/epbf_out_if.sv =====
interface epbf_out_if;
    logic                        valid;
    logic                        ready;
    logic [epbf_pkg::OUT_W-1:0]  value;
    logic                        blended;

    modport source (output valid, output value, output blended, input ready);
    modport sink (input valid, input value, input blended, output ready);
endinterface

// ===== rtl/core/epbf_alu.sv =====
module epbf_alu #(
    parameter int W = 50
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic                sub,
    output logic signed [W-1:0] sum,
    output logic                neg
);

    logic [W-1:0] b_op;

    always_comb
    begin
        b_op = sub ? ~b : b;
        sum  = a + $signed(b_op) + $signed(W'(sub));
        neg  = sum[W-1];
    end

endmodule

// ===== rtl/core/epbf_seq.sv =====
module epbf_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  epbf_pkg::sts_t  sts,
    output epbf_pkg::ctrl_t ctrl
);

    epbf_pkg::state_t                state_reg;
    epbf_pkg::state_t                state_next;
    logic [epbf_pkg::CNT_W-1:0]      cnt_reg;
    logic [epbf_pkg::CNT_W-1:0]      cnt_next;
    logic                            last;

    assign last = (cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            epbf_pkg::ST_IDLE:
            begin
                if (sts.in_fire)
                begin
                    if (sts.in_kind == epbf_pkg::KIND_SAMPLE)
                    begin
                        state_next = epbf_pkg::ST_DIFF;
                    end
                    else if (sts.in_kind == epbf_pkg::KIND_READ)
                    begin
                        state_next = epbf_pkg::ST_RCHK;
                    end
                end
            end
            epbf_pkg::ST_DIFF:
            begin
                state_next = epbf_pkg::ST_ABS;
            end
            epbf_pkg::ST_ABS:
            begin
                state_next = epbf_pkg::ST_MUL;
                cnt_next   = epbf_pkg::CNT_W'(epbf_pkg::MUL_STEPS - 1);
            end
            epbf_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (last)
                begin
                    state_next = (sts.kind == epbf_pkg::KIND_SAMPLE) ?
                                 epbf_pkg::ST_UPD : epbf_pkg::ST_RSUM;
                end
            end
            epbf_pkg::ST_UPD:
            begin
                state_next = epbf_pkg::ST_IDLE;
            end
            epbf_pkg::ST_RCHK:
            begin
                cnt_next = epbf_pkg::CNT_W'(epbf_pkg::DIV_STEPS - 1);
                if (!sts.go_blend)
                begin
                    state_next = epbf_pkg::ST_ROUT;
                end
                else if (sts.full_wt)
                begin
                    state_next = epbf_pkg::ST_RDIFF;
                end
                else
                begin
                    state_next = epbf_pkg::ST_DIV;
                end
            end
            epbf_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (last)
                begin
                    state_next = epbf_pkg::ST_RDIFF;
                end
            end
            epbf_pkg::ST_RDIFF:
            begin
                state_next = epbf_pkg::ST_MUL;
                cnt_next   = epbf_pkg::CNT_W'(epbf_pkg::MUL_STEPS - 1);
            end
            epbf_pkg::ST_RSUM:
            begin
                state_next = epbf_pkg::ST_ROUT;
            end
            epbf_pkg::ST_ROUT:
            begin
                if (sts.out_free)
                begin
                    state_next = epbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = epbf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.st       = state_reg;
        ctrl.in_ready = (state_reg == epbf_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epbf_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/ema_peak_blend_filter_top.sv =====
// Per-axis sensor conditioner: a moving-average baseline with a peak hold over a window,
// built around one shared adder that a small sequencer steps through shift-add
// multiplies and a restoring divide. The block takes one item at a time. A load item is
// taken in idle; a sample runs difference, absolute value, 17-step multiply and update.
// A read goes from the threshold check to output unblended, via difference, 17-step
// multiply and sum at full blend weight, and via the 16-step divide first otherwise. A
// finished read result sits in an output register, so the next item is taken while it
// waits; only a second read then waits for the register to drain.
module ema_peak_blend_filter_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    epbf_in_if.sink                           items,
    epbf_out_if.source                        results,
    input  logic                              cfg_we,
    input  logic [epbf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [epbf_pkg::CFG_W-1:0]        cfg_data
);

    localparam int QW = SAMPLE_WIDTH + FRAC_BITS;
    localparam int PW = QW + epbf_pkg::WT_W + 1;
    localparam int TW = epbf_pkg::THR_W + FRAC_BITS;
    localparam int CW = ((QW > TW) ? QW : TW) + 1;
    localparam int RW = ((SAMPLE_WIDTH + 1) > 17) ? (SAMPLE_WIDTH + 1) : 17;

    localparam logic signed [PW-1:0] ACC_INIT = PW'(1) << (epbf_pkg::WT_FRAC - 1);
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_HI   = RW'(epbf_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] SAT_LO   = RW'(epbf_pkg::OUT_MIN);

    epbf_pkg::ctrl_t ctrl;
    epbf_pkg::sts_t  sts;

    logic [epbf_pkg::WT_W-1:0]       weight_reg;
    logic [epbf_pkg::THR_W-1:0]      thr_reg;
    logic signed [QW-1:0]            baseline_reg;
    logic signed [QW-1:0]            baseline_next;
    logic signed [QW-1:0]            peak_val_reg;
    logic signed [QW-1:0]            peak_val_next;
    logic [QW-1:0]                   peak_dev_reg;
    logic [QW-1:0]                   peak_dev_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic [epbf_pkg::KIND_W-1:0]     kind_reg;
    logic signed [QW-1:0]            samp_reg;
    logic signed [PW-1:0]            mcand_reg;
    logic signed [PW-1:0]            mcand_next;
    logic signed [PW-1:0]            acc_reg;
    logic signed [PW-1:0]            acc_next;
    logic [epbf_pkg::WT_W-1:0]       mult_reg;
    logic [epbf_pkg::WT_W-1:0]       mult_next;
    logic signed [PW-1:0]            rem_reg;
    logic signed [PW-1:0]            rem_next;
    logic signed [QW-1:0]            v_reg;
    logic signed [QW-1:0]            v_next;
    logic                            blend_reg;
    logic                            blend_next;
    logic [epbf_pkg::OUT_W-1:0]      value_reg;
    logic [epbf_pkg::OUT_W-1:0]      value_next;
    logic                            blended_reg;
    logic                            blended_next;

    logic signed [PW-1:0]            alu_a;
    logic signed [PW-1:0]            alu_b;
    logic                            alu_sub;
    logic signed [PW-1:0]            alu_sum;
    logic                            alu_neg;

    logic                            in_fire;
    logic                            out_free;
    logic signed [QW-1:0]            s_in;
    logic [TW-1:0]                   thr_q;
    logic [CW-1:0]                   pd_c;
    logic [CW-1:0]                   t_c;
    logic [QW-1:0]                   dev_abs;
    logic signed [SAMPLE_WIDTH:0]    r_sh;
    logic signed [RW-1:0]            r_ext;

    assign in_fire  = items.valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || results.ready;
    assign s_in     = {items.sample, {FRAC_BITS{1'b0}}};
    assign thr_q    = {thr_reg, {FRAC_BITS{1'b0}}};
    assign pd_c     = CW'(peak_dev_reg);
    assign t_c      = CW'(thr_q);

    assign sts.in_fire  = in_fire;
    assign sts.in_kind  = items.kind;
    assign sts.kind     = kind_reg;
    assign sts.go_blend = (thr_reg != '0) && (pd_c > t_c);
    assign sts.full_wt  = (pd_c >= (t_c << 1));
    assign sts.out_free = out_free;

    assign items.ready     = ctrl.in_ready;
    assign results.valid   = out_valid_reg;
    assign results.value   = value_reg;
    assign results.blended = blended_reg;

    epbf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctrl  (ctrl)
    );

    epbf_alu #(
        .W (PW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .neg (alu_neg)
    );

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.st)
            epbf_pkg::ST_DIFF:
            begin
                alu_a   = PW'(samp_reg);
                alu_b   = PW'(baseline_reg);
                alu_sub = 1'b1;
            end
            epbf_pkg::ST_ABS:
            begin
                alu_b   = mcand_reg;
                alu_sub = 1'b1;
            end
            epbf_pkg::ST_MUL:
            begin
                alu_a = acc_reg;
                alu_b = mult_reg[0] ? mcand_reg : '0;
            end
            epbf_pkg::ST_UPD, epbf_pkg::ST_RSUM:
            begin
                alu_a = PW'(baseline_reg);
                alu_b = acc_reg >>> epbf_pkg::WT_FRAC;
            end
            epbf_pkg::ST_RCHK:
            begin
                alu_a   = PW'(peak_dev_reg);
                alu_b   = PW'(thr_q);
                alu_sub = 1'b1;
            end
            epbf_pkg::ST_DIV:
            begin
                alu_a   = {rem_reg[PW-2:0], 1'b0};
                alu_b   = PW'(thr_q);
                alu_sub = 1'b1;
            end
            epbf_pkg::ST_RDIFF:
            begin
                alu_a   = PW'(peak_val_reg);
                alu_b   = PW'(baseline_reg);
                alu_sub = 1'b1;
            end
            epbf_pkg::ST_ROUT:
            begin
                alu_a = PW'(v_reg);
                alu_b = HALF_LSB;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        dev_abs = mcand_reg[PW-1] ? alu_sum[QW-1:0] : mcand_reg[QW-1:0];
        r_sh    = alu_sum[QW:FRAC_BITS];
        r_ext   = RW'(r_sh);
        if (r_ext > SAT_HI)
        begin
            value_next = epbf_pkg::OUT_W'(SAT_HI);
        end
        else if (r_ext < SAT_LO)
        begin
            value_next = epbf_pkg::OUT_W'(SAT_LO);
        end
        else
        begin
            value_next = r_ext[epbf_pkg::OUT_W-1:0];
        end
        blended_next = blend_reg;
    end

    always_comb
    begin
        baseline_next  = baseline_reg;
        peak_val_next  = peak_val_reg;
        peak_dev_next  = peak_dev_reg;
        out_valid_next = out_valid_reg && !results.ready;
        mcand_next     = mcand_reg;
        acc_next       = acc_reg;
        mult_next      = mult_reg;
        rem_next       = rem_reg;
        v_next         = v_reg;
        blend_next     = blend_reg;
        case (ctrl.st)
            epbf_pkg::ST_IDLE:
            begin
                if (in_fire && (items.kind == epbf_pkg::KIND_LOAD))
                begin
                    baseline_next = s_in;
                    peak_val_next = s_in;
                    peak_dev_next = '0;
                end
            end
            epbf_pkg::ST_DIFF:
            begin
                mcand_next = alu_sum;
            end
            epbf_pkg::ST_ABS:
            begin
                if (dev_abs > peak_dev_reg)
                begin
                    peak_dev_next = dev_abs;
                    peak_val_next = samp_reg;
                end
                acc_next  = ACC_INIT;
                mult_next = weight_reg;
            end
            epbf_pkg::ST_MUL:
            begin
                acc_next   = alu_sum;
                mcand_next = mcand_reg <<< 1;
                mult_next  = mult_reg >> 1;
            end
            epbf_pkg::ST_UPD:
            begin
                baseline_next = alu_sum[QW-1:0];
            end
            epbf_pkg::ST_RCHK:
            begin
                rem_next   = alu_sum;
                mult_next  = sts.full_wt ? epbf_pkg::ONE_Q16 : '0;
                v_next     = baseline_reg;
                blend_next = sts.go_blend;
            end
            epbf_pkg::ST_DIV:
            begin
                if (!alu_neg)
                begin
                    rem_next = alu_sum;
                end
                else
                begin
                    rem_next = {rem_reg[PW-2:0], 1'b0};
                end
                mult_next = {mult_reg[epbf_pkg::WT_W-2:0], !alu_neg};
            end
            epbf_pkg::ST_RDIFF:
            begin
                mcand_next = alu_sum;
                acc_next   = ACC_INIT;
            end
            epbf_pkg::ST_RSUM:
            begin
                v_next = alu_sum[QW-1:0];
            end
            epbf_pkg::ST_ROUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    peak_dev_next  = '0;
                    peak_val_next  = baseline_reg;
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg    <= epbf_pkg::WT_W'(6554);
            thr_reg       <= '0;
            baseline_reg  <= '0;
            peak_val_reg  <= '0;
            peak_dev_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            baseline_reg  <= baseline_next;
            peak_val_reg  <= peak_val_next;
            peak_dev_reg  <= peak_dev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    epbf_pkg::REG_WEIGHT:
                    begin
                        weight_reg <= (cfg_data > epbf_pkg::ONE_Q16) ?
                                      epbf_pkg::ONE_Q16 : cfg_data;
                    end
                    epbf_pkg::REG_THRESH:
                    begin
                        thr_reg <= cfg_data[epbf_pkg::THR_W-1:0];
                    end
                    default:
                    begin
                        thr_reg <= thr_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= items.kind;
            samp_reg <= s_in;
        end
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        mult_reg  <= mult_next;
        rem_reg   <= rem_next;
        v_reg     <= v_next;
        blend_reg <= blend_next;
        if ((ctrl.st == epbf_pkg::ST_ROUT) && out_free)
        begin
            value_reg   <= value_next;
            blended_reg <= blended_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(ctrl.st == epbf_pkg::ST_ROUT))
        else $error("result appeared without a finished read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.st == epbf_pkg::ST_DIV) |-> !mult_reg[epbf_pkg::WT_W-1])
        else $error("divide quotient overflowed its weight range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.blended) |-> (thr_reg != '0))
        else $error("blended result with blending disabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.st == epbf_pkg::ST_UPD) |=> (ctrl.st == epbf_pkg::ST_IDLE && !results.valid) ||
                                          (ctrl.st == epbf_pkg::ST_IDLE))
        else $error("sample update did not return to idle");

endmodule
